// ===== rtl/cec_pkg.sv =====
package cec_pkg;

    // Ease modes, as written to register index zero.
    localparam logic [1:0] MODE_IN    = 2'd0;
    localparam logic [1:0] MODE_OUT   = 2'd1;
    localparam logic [1:0] MODE_INOUT = 2'd2;
    localparam logic [1:0] MODE_ZERO  = 2'd3;

    // Register indexes on the configuration port.
    localparam logic REG_MODE     = 1'b0;
    localparam logic REG_DURATION = 1'b1;

    localparam int ELAPSED_W = 16;
    localparam int OUT_W     = 17;

    // Control that travels along the chain with each transaction.
    typedef struct packed {
        logic valid;
        logic sat;
        logic low;
    } t_ctl;

endpackage

// ===== rtl/circular_easing_curve.sv =====
// Circular easing: each elapsed tick count is clamped to the configured
// duration, normalised to t in [0, 1] and mapped through the selected
// circular ease, giving an unsigned Q1.16 fraction where 65536 is 1.0.
// The pipeline takes one transaction every cycle while the output is not
// stalled and returns results in order, through 2*FRAC_BITS+4 register
// stages: FRAC_BITS divider cells, one register to fold t for the mode,
// one for the square, FRAC_BITS+1 square root cells and the output
// register. A stalled output holds the whole chain. Configuration is
// written by the user only while idle; the block does not enforce this.
module circular_easing_curve #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [cec_pkg::ELAPSED_W-1:0] i_elapsed_ticks,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [cec_pkg::OUT_W-1:0]     o_eased_fraction
);
    import cec_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int ROOT_W = F + 1;
    localparam int V_W    = F + 2;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [1:0]  r_mode;
    logic [15:0] r_dur;
    logic        en;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IN;
            r_dur  <= 16'd1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MODE) begin
                r_mode <= i_cfg_data[1:0];
            end else begin
                r_dur  <= i_cfg_data;
            end
        end
    end

    // Divider chain.
    t_ctl        div_ctl [0:F];
    logic [15:0] div_rem [0:F];
    logic [F-1:0] div_quo [0:F];

    always_comb begin
        div_ctl[0].valid = i_valid;
        div_ctl[0].sat   = (r_dur == 16'd0) || (i_elapsed_ticks >= r_dur);
        div_ctl[0].low   = 1'b0;
        div_rem[0]       = i_elapsed_ticks;
        div_quo[0]       = '0;
    end

    for (genvar k = 0; k < F; k++) begin : g_div
        cec_div_cell #(.FRAC_BITS(F)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_den   (r_dur),
            .i_ctl   (div_ctl[k]),
            .i_rem   (div_rem[k]),
            .i_quo   (div_quo[k]),
            .o_ctl   (div_ctl[k+1]),
            .o_rem   (div_rem[k+1]),
            .o_quo   (div_quo[k+1])
        );
    end

    // Fold t into the argument of sqrt(1 - x^2) for the mode.
    logic [F:0]   n_t;
    logic [F+1:0] n_u;
    logic [F:0]   n_x;
    logic         n_low;
    t_ctl         r_a_ctl;
    logic [F:0]   r_a_x;

    always_comb begin
        n_t   = div_ctl[F].sat ? ONE : {1'b0, div_quo[F]};
        n_u   = {n_t, 1'b0};
        n_low = n_u < {1'b0, ONE};
        unique case (r_mode)
            MODE_IN:    n_x = n_t;
            MODE_OUT:   n_x = ONE - n_t;
            MODE_INOUT: n_x = n_low ? n_u[F:0] : (F+1)'({ONE, 1'b0} - n_u);
            default:    n_x = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctl <= '0;
        end else if (en) begin
            r_a_ctl <= '{valid: div_ctl[F].valid, sat: 1'b0, low: n_low};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_x <= n_x;
        end
    end

    // Radicand 2^(2F) - x^2.
    logic [2*ROOT_W-1:0] n_sq;
    t_ctl                sq_ctl [0:ROOT_W];
    logic [ROOT_W+1:0]   sq_rem [0:ROOT_W];
    logic [ROOT_W-1:0]   sq_root [0:ROOT_W];
    logic [2*ROOT_W-1:0] sq_rad [0:ROOT_W];
    t_ctl                r_b_ctl;
    logic [2*ROOT_W-1:0] r_b_rad;

    assign n_sq = {{(2*ROOT_W-F-1){1'b0}}, r_a_x} * {{(2*ROOT_W-F-1){1'b0}}, r_a_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctl <= '0;
        end else if (en) begin
            r_b_ctl <= r_a_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_rad <= ((2*ROOT_W)'(1) << (2*F)) - n_sq;
        end
    end

    always_comb begin
        sq_ctl[0]  = r_b_ctl;
        sq_rem[0]  = '0;
        sq_root[0] = '0;
        sq_rad[0]  = r_b_rad;
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        cec_sqrt_cell #(.ROOT_W(ROOT_W)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (sq_ctl[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_rad   (sq_rad[k]),
            .o_ctl   (sq_ctl[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_rad   (sq_rad[k+1])
        );
    end

    // Bring a Q.g value to Q1.16, rounding half up when narrowing.
    function automatic logic [OUT_W-1:0] to_q16(input logic [V_W-1:0] v, input int g);
        logic [V_W+16:0] ext;
        ext = {17'd0, v};
        if (g > 16) begin
            ext = (ext + ((V_W+17)'(1) << (g - 17))) >> (g - 16);
        end else if (g < 16) begin
            ext = ext << (16 - g);
        end
        return ext[OUT_W-1:0];
    endfunction

    logic [V_W-1:0]   n_s;
    logic [OUT_W-1:0] n_frac;

    always_comb begin
        n_s = {1'b0, sq_root[ROOT_W]};
        unique case (r_mode)
            MODE_IN:    n_frac = to_q16({1'b0, ONE} - n_s, F);
            MODE_OUT:   n_frac = to_q16(n_s, F);
            MODE_INOUT: n_frac = sq_ctl[ROOT_W].low ? to_q16({1'b0, ONE} - n_s, F + 1)
                                                    : to_q16({1'b0, ONE} + n_s, F + 1);
            default:    n_frac = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= sq_ctl[ROOT_W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_eased_fraction <= n_frac;
        end
    end

`ifndef SYNTHESIS
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_eased_fraction <= 17'd65536)
        else $error("eased fraction above one");
    a_zero_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_mode == MODE_ZERO) |-> o_eased_fraction == '0)
        else $error("zero mode gave a non-zero fraction");
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without an output stall");
`endif

endmodule

// ===== rtl/cec_div_cell.sv =====
module cec_div_cell #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [15:0]           i_den,
    input  cec_pkg::t_ctl         i_ctl,
    input  logic [15:0]           i_rem,
    input  logic [FRAC_BITS-1:0]  i_quo,
    output cec_pkg::t_ctl         o_ctl,
    output logic [15:0]           o_rem,
    output logic [FRAC_BITS-1:0]  o_quo
);
    import cec_pkg::*;

    logic [16:0] n_rem2;
    logic        n_ge;
    logic [16:0] n_diff;

    // One restoring division step: one quotient bit per cell.
    always_comb begin
        n_rem2 = {i_rem, 1'b0};
        n_ge   = n_rem2 >= {1'b0, i_den};
        n_diff = n_rem2 - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_ge ? n_diff[15:0] : n_rem2[15:0];
            o_quo <= {i_quo[FRAC_BITS-2:0], n_ge};
        end
    end

endmodule

// ===== rtl/cec_sqrt_cell.sv =====
module cec_sqrt_cell #(
    parameter int ROOT_W = 17
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  cec_pkg::t_ctl         i_ctl,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output cec_pkg::t_ctl         o_ctl,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root,
    output logic [2*ROOT_W-1:0]   o_rad
);
    import cec_pkg::*;

    logic [ROOT_W+1:0] n_rem2;
    logic [ROOT_W+1:0] n_trial;
    logic              n_ge;

    // One root bit per cell: bring down the next two radicand bits and try
    // four times the partial root plus one.
    always_comb begin
        n_rem2  = {i_rem[ROOT_W-1:0], i_rad[2*ROOT_W-1:2*ROOT_W-2]};
        n_trial = {i_root, 2'b01};
        n_ge    = n_rem2 >= n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl <= '0;
        end else if (i_en) begin
            o_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_ge ? n_rem2 - n_trial : n_rem2;
            o_root <= {i_root[ROOT_W-2:0], n_ge};
            o_rad  <= {i_rad[2*ROOT_W-3:0], 2'b00};
        end
    end

endmodule
